>>> sv/acpsm_pkg.sv
// Package for the AC pulse-skip modulator.
// Holds field widths, register index codes, event kinds and the result word type.
// No dependencies.
`default_nettype none

package acpsm_pkg;

    localparam int unsigned NOW_W      = 32;
    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned DIV_W      = 8;
    localparam int unsigned GAP_W      = 8;
    localparam int unsigned STOP_W     = 31;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 31;
    localparam int unsigned S_DATA_W   = 56;
    localparam int unsigned M_DATA_W   = 40;

    localparam logic [LEVEL_W-1:0] FULL_RANGE_RESET = 16'd100;
    localparam logic [DIV_W-1:0]   DIVIDER_RESET    = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_RANGE     = 3'd0,
        CFG_EVENT_DIVIDER  = 3'd1,
        CFG_MIN_GAP_MS     = 3'd2,
        CFG_STOP_LIMIT     = 3'd3,
        CFG_PULSE_TIMER_ON = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        KIND_ZERO_CROSS  = 1'b0,
        KIND_TIMER_EXPIRY = 1'b1
    } t_kind;

    typedef struct packed {
        logic [COUNT_W-1:0] fired_count;
        logic               restart_timer;
        logic               accepted;
        logic               drive;
    } t_result;

endpackage

`default_nettype wire

>>> sv/ac_pulse_skip_modulator.sv
// Top level of the AC pulse-skip modulator: gap filter, event divider,
// error accumulator, fire counter, and a two-word output queue.
// Depends on acpsm_pkg.
//
// Usage:
//   Slave stream carries one event word: tuser is the kind (0 zero crossing,
//   1 pulse timer expiry); tdata holds now_ms, level and clear_count.
//   Master stream returns one result word per event: drive, accepted,
//   restart_timer and fired_count.
//   Configuration channel writes one register per handshake; o_cfg_ready is
//   always high. Write registers only while no event is in flight.
//   The taken event word is held in the input register, which feeds the
//   compute logic; the compute logic loads the result into the output
//   register, or into the skid register when the output register is full.
//   Throughput: one event per cycle, set by the single-pass compute stage.
//   When the receiver stalls, a skid register holds one more result; the
//   input register holds while the skid is full, and tready drops.
//   Reset (synchronous, active low) restores register defaults, clears the
//   accumulator, divider, fire count and drive, and empties all stages.
`default_nettype none

module ac_pulse_skip_modulator #(
    parameter int unsigned LEVEL_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // slave event stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [31:0] now_ms, [47:32] level, [48] clear_count, [55:49] zero
    input  wire logic [acpsm_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // [0] kind
    input  wire logic                                s_axis_tuser,
    // master result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [0] drive, [1] accepted, [2] restart_timer, [34:3] fired_count, [39:35] zero
    output logic [acpsm_pkg::M_DATA_W-1:0]           m_axis_tdata,
    // configuration write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [acpsm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [acpsm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned LW = (LEVEL_BITS < acpsm_pkg::LEVEL_W) ?
                                 LEVEL_BITS : acpsm_pkg::LEVEL_W;
    localparam int unsigned AW = LEVEL_BITS + 1;

    // configuration registers
    logic [LW-1:0]                     r_full_range;
    logic [acpsm_pkg::DIV_W-1:0]       r_event_divider;
    logic [acpsm_pkg::GAP_W-1:0]       r_min_gap;
    logic [acpsm_pkg::STOP_W-1:0]      r_stop_limit;
    logic                              r_pulse_on;

    // modulator state
    logic [acpsm_pkg::NOW_W-1:0]       r_last_ms,    n_last_ms;
    logic [acpsm_pkg::DIV_W-1:0]       r_div_count,  n_div_count;
    logic [AW-1:0]                     r_accum,      n_accum;
    logic                              r_skip,       n_skip;
    logic [acpsm_pkg::COUNT_W-1:0]     r_fire_total, n_fire_total;
    logic                              r_drive,      n_drive;

    // input register
    logic                              r_in_valid;
    logic                              r_in_kind;
    logic [acpsm_pkg::NOW_W-1:0]       r_in_now;
    logic [acpsm_pkg::LEVEL_W-1:0]     r_in_level;
    logic                              r_in_clr;

    // output queue
    logic                              r_out_valid;
    acpsm_pkg::t_result                r_out;
    logic                              r_skid_valid;
    acpsm_pkg::t_result                r_skid;

    acpsm_pkg::t_result                w_res;
    logic                              w_push;
    logic                              w_pop;
    logic                              w_take;
    logic [acpsm_pkg::NOW_W-1:0]       w_gap_diff;
    logic                              w_reject;
    logic [LW-1:0]                     w_lvl;
    logic [AW-1:0]                     w_sum;
    logic [AW-1:0]                     w_range;
    logic                              w_skip;

    assign o_cfg_ready   = 1'b1;
    assign w_push        = r_in_valid && !r_skid_valid;
    assign w_pop         = r_out_valid && m_axis_tready;
    assign s_axis_tready = !r_in_valid || !r_skid_valid;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(acpsm_pkg::M_DATA_W - $bits(acpsm_pkg::t_result)){1'b0}}, r_out};
    assign w_range       = {{(AW-LW){1'b0}}, r_full_range};

    always_comb begin
        n_last_ms    = r_last_ms;
        n_div_count  = r_div_count;
        n_accum      = r_accum;
        n_skip       = r_skip;
        n_fire_total = r_in_clr ? '0 : r_fire_total;
        n_drive      = r_drive;
        w_res        = '0;
        w_gap_diff   = r_in_now - {{(acpsm_pkg::NOW_W - acpsm_pkg::GAP_W){1'b0}}, r_min_gap};
        w_reject     = (r_min_gap != '0) && (w_gap_diff < r_last_ms) &&
                       (r_in_now >= r_last_ms);
        w_lvl        = (r_in_level[LW-1:0] > r_full_range) ? r_full_range
                                                            : r_in_level[LW-1:0];
        w_sum        = '0;
        w_skip       = r_skip;
        if (r_in_kind == acpsm_pkg::KIND_ZERO_CROSS) begin
            if (!w_reject) begin
                w_res.accepted      = 1'b1;
                w_res.restart_timer = r_pulse_on;
                n_last_ms           = r_in_now;
                if (r_div_count >= r_event_divider) begin
                    n_div_count = r_div_count - r_event_divider;
                    w_sum       = r_accum + {{(AW-LW){1'b0}}, w_lvl};
                    if (w_sum >= w_range) begin
                        w_sum  = w_sum - w_range;
                        w_skip = 1'b0;
                    end else begin
                        w_skip = 1'b1;
                    end
                    if (w_sum > w_range) begin
                        w_sum  = '0;
                        w_skip = 1'b0;
                    end
                    if (!w_skip) begin
                        if (n_fire_total != '1) begin
                            n_fire_total = n_fire_total +
                                           {{(acpsm_pkg::COUNT_W-1){1'b0}}, 1'b1};
                        end
                        if ((r_stop_limit != '0) &&
                            (n_fire_total > {1'b0, r_stop_limit})) begin
                            w_skip = 1'b1;
                        end
                    end
                    n_accum = w_sum;
                    n_skip  = w_skip;
                end else begin
                    n_div_count = r_div_count + {{(acpsm_pkg::DIV_W-1){1'b0}}, 1'b1};
                end
                n_drive = !n_skip;
            end
        end else begin
            n_drive = 1'b0;
        end
        w_res.drive       = n_drive;
        w_res.fired_count = n_fire_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_range    <= acpsm_pkg::FULL_RANGE_RESET[LW-1:0];
            r_event_divider <= acpsm_pkg::DIVIDER_RESET;
            r_min_gap       <= '0;
            r_stop_limit    <= '0;
            r_pulse_on      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                acpsm_pkg::CFG_FULL_RANGE: begin
                    r_full_range <= i_cfg_data[LW-1:0];
                end
                acpsm_pkg::CFG_EVENT_DIVIDER: begin
                    r_event_divider <= (i_cfg_data[acpsm_pkg::DIV_W-1:0] == '0) ?
                                       acpsm_pkg::DIVIDER_RESET :
                                       i_cfg_data[acpsm_pkg::DIV_W-1:0];
                end
                acpsm_pkg::CFG_MIN_GAP_MS: begin
                    r_min_gap <= i_cfg_data[acpsm_pkg::GAP_W-1:0];
                end
                acpsm_pkg::CFG_STOP_LIMIT: begin
                    r_stop_limit <= i_cfg_data[acpsm_pkg::STOP_W-1:0];
                end
                acpsm_pkg::CFG_PULSE_TIMER_ON: begin
                    r_pulse_on <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ms    <= '0;
            r_div_count  <= '0;
            r_accum      <= '0;
            r_skip       <= 1'b1;
            r_fire_total <= '0;
            r_drive      <= 1'b0;
        end else if (w_push) begin
            r_last_ms    <= n_last_ms;
            r_div_count  <= n_div_count;
            r_accum      <= n_accum;
            r_skip       <= n_skip;
            r_fire_total <= n_fire_total;
            r_drive      <= n_drive;
        end
    end

    // input register: load on take, drop when pushed onward
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_push) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_kind  <= s_axis_tuser;
            r_in_now   <= s_axis_tdata[31:0];
            r_in_level <= s_axis_tdata[47:32];
            r_in_clr   <= s_axis_tdata[48];
        end
    end

    // output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_push) begin
                r_out <= w_res;
            end
        end else if (w_push) begin
            r_skid <= w_res;
        end
    end

    a_skid_needs_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a word while output register is empty");

    a_restart_needs_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.restart_timer) |-> r_out.accepted)
        else $error("timer restart without an accepted crossing");

    a_divider_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_event_divider != '0))
        else $error("event divider holds zero");

    a_expiry_drops_drive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && (r_in_kind == acpsm_pkg::KIND_TIMER_EXPIRY)) |=> !r_drive)
        else $error("drive high after timer expiry");

endmodule

`default_nettype wire
